/* hw/rtl/gmbsi_pkg.sv */
// Package for the bilinear grid map interpolator: field widths, fixed-point
// constants, parameter defaults and item codes.
// No dependencies.
package gmbsi_pkg;

	// item codes
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// parameter defaults
	localparam int MAP_HOURS_DEF  = 24;
	localparam int LNG_POINTS_DEF = 241;
	localparam int LAT_POINTS_DEF = 121;

	// field widths
	localparam int HOUR_W  = 5;
	localparam int LNGP_W  = 25;
	localparam int LATP_W  = 24;
	localparam int SSN_W   = 8;
	localparam int LNGI_W  = 8;
	localparam int LATI_W  = 7;
	localparam int VAL_W   = 16;
	localparam int ENTRY_W = 4 * VAL_W;

	localparam logic [SSN_W-1:0] MAX_SSN_RESET = 8'd160;

	// positions in 2^-16 degree, one cell is 1.5 degree = 3 * 2^15
	localparam int CELL_STEP  = 98304;
	localparam int STEP_W     = 17;
	localparam int LNG_OFFSET = 11796480;
	localparam int LAT_OFFSET = 5898240;
	localparam int CELL_SHIFT = 15;
	// floor(t / 3) = (t * RECIP_3) >> 13 for t < 2048
	localparam int RECIP_3       = 2731;
	localparam int RECIP_3_SHIFT = 13;

	// weight and sum widths
	localparam int WGT_W  = 2 * STEP_W;
	localparam int PROD_W = WGT_W + VAL_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int NUM_W  = 62;

	// denominator is 100 * STEP^2 = 900 * 2^30; half of it is 450 * 2^30
	localparam int NUM_SHIFT = 30;
	localparam int QBIAS     = 450;
	localparam int SAT_LIMIT = 58982400;  // 65536 * 900
	localparam int T3_W      = 24;
	// floor(t / 225) = (t * RECIP_225) >> 32 for t < 2^24
	localparam int RECIP_225 = 19088744;
	localparam int RECIP_W   = 25;
	localparam int QPROD_W   = T3_W + RECIP_W;

endpackage

/* hw/rtl/grid_map_bilinear_ssn_interp.sv */
// Top level of the bilinear grid map interpolator: banked map store and the
// ten-stage query pipeline. Depends on gmbsi_pkg.
//
// Holds foF2 and M(3000)F2 maps for each hour on a 1.5 degree grid, each point
// carrying values for R12 0 and 100. A load item (kind 0) writes one grid
// point; out-of-range loads are dropped. A query item (kind 1) gives latitude
// and longitude in degrees with 16 fraction bits, an hour and a sunspot number;
// it returns one result with foF2 and M(3000)F2 bilinearly interpolated over
// the four surrounding grid points and then linearly interpolated (or
// extrapolated above 100) in sunspot number capped at max_ssn, rounded half up
// and saturated to 0..65535. One item is taken every cycle unless out_ready
// stalls the pipe; a query result is presented from the stage 10 register,
// loads give no result. The rate is set by the map store: it is split into
// four banks by column and row parity, so the four neighbours of any cell sit
// in four different banks and are read in the same cycle, one read port per
// bank, with the load write port on the same stage so that items see the maps
// in transfer order. Map contents are undefined until loaded; there is no
// clearing pass. max_ssn resets to 160; the user must write it through the
// configuration channel while the block is idle; the block does not enforce it.
module grid_map_bilinear_ssn_interp #(
	parameter int MAP_HOURS  = gmbsi_pkg::MAP_HOURS_DEF,
	parameter int LNG_POINTS = gmbsi_pkg::LNG_POINTS_DEF,
	parameter int LAT_POINTS = gmbsi_pkg::LAT_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gmbsi_pkg::SSN_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [gmbsi_pkg::HOUR_W-1:0]        hour,
	input  logic signed [gmbsi_pkg::LNGP_W-1:0] lng_pos,
	input  logic signed [gmbsi_pkg::LATP_W-1:0] lat_pos,
	input  logic [gmbsi_pkg::SSN_W-1:0]         sunspot,
	input  logic [gmbsi_pkg::LNGI_W-1:0]        lng_index,
	input  logic [gmbsi_pkg::LATI_W-1:0]        lat_index,
	input  logic [gmbsi_pkg::VAL_W-1:0]         fof2_at_zero,
	input  logic [gmbsi_pkg::VAL_W-1:0]         fof2_at_hundred,
	input  logic [gmbsi_pkg::VAL_W-1:0]         mfactor_at_zero,
	input  logic [gmbsi_pkg::VAL_W-1:0]         mfactor_at_hundred,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gmbsi_pkg::VAL_W-1:0]         fof2_out,
	output logic [gmbsi_pkg::VAL_W-1:0]         mfactor_out,
	output logic                                saturated
);
	import gmbsi_pkg::*;

	localparam int CW = (LNG_POINTS > 1) ? $clog2(LNG_POINTS) : 1;
	localparam int RW = (LAT_POINTS > 1) ? $clog2(LAT_POINTS) : 1;
	localparam int LH = (LNG_POINTS + 1) / 2;
	localparam int RH = (LAT_POINTS + 1) / 2;
	localparam int BANK_DEPTH = MAP_HOURS * LH * RH;
	localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int UW = LNGP_W + 1;
	localparam int VW = LATP_W + 1;

	// halves of one map word: f0, f1, m0, m1
	localparam int NHALF = 4;

	// ---------------- configuration ----------------
	logic [SSN_W-1:0] max_ssn_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ssn_q <= MAX_SSN_RESET;
		end else if (cfg_valid) begin
			max_ssn_q <= cfg_data;
		end
	end

	// ---------------- stage flow ----------------
	// each stage moves when it is empty or its successor moves, so bubbles fill
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9, adv10;

	assign adv10 = !vld_s10 || out_ready;
	assign adv9  = !vld_s9 || adv10;
	assign adv8  = !vld_s8 || adv9;
	assign adv7  = !vld_s7 || adv8;
	assign adv6  = !vld_s6 || adv7;
	assign adv5  = !vld_s5 || adv6;
	assign adv4  = !vld_s4 || adv5;
	assign adv3  = !vld_s3 || adv4;
	assign adv2  = !vld_s2 || adv3;
	assign adv1  = !vld_s1 || adv2;
	assign in_ready = adv1;

	// ---------------- stage 1: decode ----------------
	logic                   kind_s1;
	logic [HOUR_W-1:0]      hour_s1;
	logic signed [UW-1:0]   lngu_s1;
	logic signed [VW-1:0]   latv_s1;
	logic [SSN_W-1:0]       ssn_s1;
	logic [LNGI_W-1:0]      lidx_s1;
	logic [LATI_W-1:0]      kidx_s1;
	logic                   ldok_s1;
	logic [ENTRY_W-1:0]     data_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1 <= kind;
			// queries past the last hour use the last map
			if (kind == KIND_QUERY && 32'(hour) >= MAP_HOURS)
				hour_s1 <= HOUR_W'(MAP_HOURS - 1);
			else
				hour_s1 <= hour;
			lngu_s1 <= UW'(lng_pos) + UW'(LNG_OFFSET);
			latv_s1 <= VW'(lat_pos) + VW'(LAT_OFFSET);
			ssn_s1  <= (sunspot > max_ssn_q) ? max_ssn_q : sunspot;
			lidx_s1 <= lng_index;
			kidx_s1 <= lat_index;
			ldok_s1 <= (32'(hour) < MAP_HOURS) && (32'(lng_index) < LNG_POINTS)
				&& (32'(lat_index) < LAT_POINTS);
			data_s1 <= {mfactor_at_hundred, mfactor_at_zero, fof2_at_hundred, fof2_at_zero};
		end
	end

	// ---------------- stage 2: cell corner ----------------
	logic                 kind_s2;
	logic [HOUR_W-1:0]    hour_s2;
	logic signed [UW-1:0] lngu_s2;
	logic signed [VW-1:0] latv_s2;
	logic [SSN_W-1:0]     ssn_s2;
	logic                 ldok_s2;
	logic [ENTRY_W-1:0]   data_s2;
	logic [CW-1:0]        j0_s2;
	logic [RW-1:0]        k0_s2;

	logic [CW-1:0] j0_c;
	logic [RW-1:0] k0_c;

	always_comb begin
		logic [21:0] pj;
		logic [20:0] pk;
		logic [8:0]  qj;
		logic [7:0]  qk;
		// floor(pos / STEP) = floor((pos >> 15) / 3)
		pj = 22'(lngu_s1[UW-2:CELL_SHIFT]) * 22'(RECIP_3);
		pk = 21'(latv_s1[VW-2:CELL_SHIFT]) * 21'(RECIP_3);
		qj = pj[21:RECIP_3_SHIFT];
		qk = pk[20:RECIP_3_SHIFT];
		if (kind_s1 == KIND_LOAD)
			j0_c = CW'(lidx_s1);
		else if (lngu_s1[UW-1])
			j0_c = '0;
		else if (32'(qj) > LNG_POINTS - 1)
			j0_c = CW'(LNG_POINTS - 1);
		else
			j0_c = CW'(qj);
		if (kind_s1 == KIND_LOAD)
			k0_c = RW'(kidx_s1);
		else if (latv_s1[VW-1])
			k0_c = '0;
		else if (32'(qk) > LAT_POINTS - 1)
			k0_c = RW'(LAT_POINTS - 1);
		else
			k0_c = RW'(qk);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			kind_s2 <= kind_s1;
			hour_s2 <= hour_s1;
			lngu_s2 <= lngu_s1;
			latv_s2 <= latv_s1;
			ssn_s2  <= ssn_s1;
			ldok_s2 <= ldok_s1;
			data_s2 <= data_s1;
			j0_s2   <= j0_c;
			k0_s2   <= k0_c;
		end
	end

	// ---------------- stage 3: offsets, far corner ----------------
	logic                 kind_s3;
	logic [HOUR_W-1:0]    hour_s3;
	logic [SSN_W-1:0]     ssn_s3;
	logic                 ldok_s3;
	logic [ENTRY_W-1:0]   data_s3;
	logic [CW-1:0]        j0_s3, j1_s3;
	logic [RW-1:0]        k0_s3, k1_s3;
	logic [STEP_W-1:0]    rj_s3, rk_s3;

	logic [STEP_W-1:0] rj_c, rk_c;
	logic [CW-1:0]     j1_c;
	logic [RW-1:0]     k1_c;

	always_comb begin
		logic signed [UW:0] dj;
		logic signed [VW:0] dk;
		dj = (UW+1)'(lngu_s2) - (UW+1)'(j0_s2) * (UW+1)'(CELL_STEP);
		dk = (VW+1)'(latv_s2) - (VW+1)'(k0_s2) * (VW+1)'(CELL_STEP);
		if (dj < 0)
			rj_c = '0;
		else if (dj > (UW+1)'(CELL_STEP))
			rj_c = STEP_W'(CELL_STEP);
		else
			rj_c = dj[STEP_W-1:0];
		if (dk < 0)
			rk_c = '0;
		else if (dk > (VW+1)'(CELL_STEP))
			rk_c = STEP_W'(CELL_STEP);
		else
			rk_c = dk[STEP_W-1:0];
		// edge points are their own far neighbour; loads use the point itself
		if (kind_s2 == KIND_QUERY && 32'(j0_s2) < LNG_POINTS - 1)
			j1_c = j0_s2 + CW'(1);
		else
			j1_c = j0_s2;
		if (kind_s2 == KIND_QUERY && 32'(k0_s2) < LAT_POINTS - 1)
			k1_c = k0_s2 + RW'(1);
		else
			k1_c = k0_s2;
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			kind_s3 <= kind_s2;
			hour_s3 <= hour_s2;
			ssn_s3  <= ssn_s2;
			ldok_s3 <= ldok_s2;
			data_s3 <= data_s2;
			j0_s3   <= j0_s2;
			j1_s3   <= j1_c;
			k0_s3   <= k0_s2;
			k1_s3   <= k1_c;
			rj_s3   <= rj_c;
			rk_s3   <= rk_c;
		end
	end

	// ---------------- stage 4: bank addresses, weights ----------------
	logic               kind_s4;
	logic [SSN_W-1:0]   ssn_s4;
	logic [3:0]         wen_s4;
	logic [ENTRY_W-1:0] data_s4;
	logic [AW-1:0]      addr_s4 [4];
	logic [WGT_W-1:0]   wgt_s4 [4];
	logic               jp0_s4, jp1_s4, kp0_s4, kp1_s4;

	logic [AW-1:0]    addr_c [4];
	logic [WGT_W-1:0] wgt_c [4];
	logic [3:0]       wen_c;

	always_comb begin
		logic [CW-1:0]     col [2];
		logic [RW-1:0]     row [2];
		logic [STEP_W-1:0] wx0, wy0;
		for (int p = 0; p < 2; p++) begin
			col[p] = (j0_s3[0] == 1'(p)) ? j0_s3 : j1_s3;
			row[p] = (k0_s3[0] == 1'(p)) ? k0_s3 : k1_s3;
		end
		// bank b = {column parity, row parity}
		for (int b = 0; b < 4; b++) begin
			addr_c[b] = AW'((32'(hour_s3) * LH + 32'(col[b/2] >> 1)) * RH
				+ 32'(row[b%2] >> 1));
			wen_c[b] = vld_s3 && (kind_s3 == KIND_LOAD) && ldok_s3
				&& ({j0_s3[0], k0_s3[0]} == 2'(b));
		end
		wx0 = STEP_W'(CELL_STEP) - rj_s3;
		wy0 = STEP_W'(CELL_STEP) - rk_s3;
		wgt_c[0] = WGT_W'(wx0) * WGT_W'(wy0);      // lower left
		wgt_c[1] = WGT_W'(rj_s3) * WGT_W'(wy0);    // lower right
		wgt_c[2] = WGT_W'(wx0) * WGT_W'(rk_s3);    // upper left
		wgt_c[3] = WGT_W'(rj_s3) * WGT_W'(rk_s3);  // upper right
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			kind_s4 <= kind_s3;
			ssn_s4  <= ssn_s3;
			wen_s4  <= wen_c;
			data_s4 <= data_s3;
			addr_s4 <= addr_c;
			wgt_s4  <= wgt_c;
			jp0_s4  <= j0_s3[0];
			jp1_s4  <= j1_s3[0];
			kp0_s4  <= k0_s3[0];
			kp1_s4  <= k1_s3[0];
		end
	end

	// ---------------- stage 5: map banks ----------------
	logic [ENTRY_W-1:0] rd_s5 [4];
	logic [SSN_W-1:0]   ssn_s5;
	logic [WGT_W-1:0]   wgt_s5 [4];
	logic               jp0_s5, jp1_s5, kp0_s5, kp1_s5;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [ENTRY_W-1:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (adv5) begin
				if (vld_s4 && wen_s4[b])
					mem[addr_s4[b]] <= data_s4;
				rd_s5[b] <= mem[addr_s4[b]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			ssn_s5 <= ssn_s4;
			wgt_s5 <= wgt_s4;
			jp0_s5 <= jp0_s4;
			jp1_s5 <= jp1_s4;
			kp0_s5 <= kp0_s4;
			kp1_s5 <= kp1_s4;
		end
	end

	// ---------------- stage 6: weighted corners ----------------
	logic [SSN_W-1:0]  ssn_s6;
	logic [PROD_W-1:0] prod_s6 [4][NHALF];

	logic [PROD_W-1:0] prod_c [4][NHALF];

	always_comb begin
		logic [ENTRY_W-1:0] cv [4];
		cv[0] = rd_s5[{jp0_s5, kp0_s5}];
		cv[1] = rd_s5[{jp1_s5, kp0_s5}];
		cv[2] = rd_s5[{jp0_s5, kp1_s5}];
		cv[3] = rd_s5[{jp1_s5, kp1_s5}];
		for (int c = 0; c < 4; c++)
			for (int h = 0; h < NHALF; h++)
				prod_c[c][h] = PROD_W'(cv[c][h*VAL_W +: VAL_W]) * PROD_W'(wgt_s5[c]);
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			ssn_s6  <= ssn_s5;
			prod_s6 <= prod_c;
		end
	end

	// ---------------- stage 7: bilinear sums ----------------
	logic [SSN_W-1:0] ssn_s7;
	logic [SUM_W-1:0] sum_s7 [NHALF];

	always_ff @(posedge clk) begin
		if (adv7) begin
			ssn_s7 <= ssn_s6;
			for (int h = 0; h < NHALF; h++)
				sum_s7[h] <= SUM_W'(prod_s6[0][h]) + SUM_W'(prod_s6[1][h])
					+ SUM_W'(prod_s6[2][h]) + SUM_W'(prod_s6[3][h]);
		end
	end

	// ---------------- stage 8: sunspot blend ----------------
	logic signed [NUM_W-1:0] num_s8 [2];

	always_ff @(posedge clk) begin
		if (adv8) begin
			for (int m = 0; m < 2; m++)
				num_s8[m] <= NUM_W'($signed({1'b0, sum_s7[2*m+1]})
						* $signed({1'b0, ssn_s7}))
					+ NUM_W'($signed({1'b0, sum_s7[2*m]})
						* ($signed(10'sd100) - $signed({2'b00, ssn_s7})));
		end
	end

	// ---------------- stage 9: rounding, range check ----------------
	// (num + 450*2^30) >> 30 == (num >> 30) + 450, floor division throughout
	logic            neg_s9 [2];
	logic            big_s9 [2];
	logic [T3_W-1:0] t3_s9 [2];

	always_ff @(posedge clk) begin
		if (adv9) begin
			for (int m = 0; m < 2; m++) begin
				logic signed [NUM_W-NUM_SHIFT-1:0] t2;
				t2 = (NUM_W-NUM_SHIFT)'(num_s8[m] >>> NUM_SHIFT)
					+ (NUM_W-NUM_SHIFT)'(QBIAS);
				neg_s9[m] <= t2[NUM_W-NUM_SHIFT-1];
				big_s9[m] <= !t2[NUM_W-NUM_SHIFT-1]
					&& (t2 >= (NUM_W-NUM_SHIFT)'(SAT_LIMIT));
				t3_s9[m]  <= t2[T3_W+1:2];
			end
		end
	end

	// ---------------- stage 10: divide by 225, result register ----------------
	logic               neg_s10 [2];
	logic               big_s10 [2];
	logic [QPROD_W-1:0] q_s10 [2];

	always_ff @(posedge clk) begin
		if (adv10) begin
			for (int m = 0; m < 2; m++) begin
				neg_s10[m] <= neg_s9[m];
				big_s10[m] <= big_s9[m];
				q_s10[m]   <= QPROD_W'(t3_s9[m]) * QPROD_W'(RECIP_225);
			end
		end
	end

	logic [VAL_W-1:0] res [2];

	always_comb begin
		for (int m = 0; m < 2; m++) begin
			if (neg_s10[m])
				res[m] = '0;
			else if (big_s10[m])
				res[m] = '1;
			else
				res[m] = q_s10[m][32 +: VAL_W];
		end
	end

	assign out_valid   = vld_s10;
	assign fof2_out    = res[0];
	assign mfactor_out = res[1];
	assign saturated   = neg_s10[0] || big_s10[0] || neg_s10[1] || big_s10[1];

	// ---------------- valid bits ----------------
	// loads leave the pipe once they have passed the banks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (adv1)  vld_s1  <= in_valid;
			if (adv2)  vld_s2  <= vld_s1;
			if (adv3)  vld_s3  <= vld_s2;
			if (adv4)  vld_s4  <= vld_s3;
			if (adv5)  vld_s5  <= vld_s4 && (kind_s4 == KIND_QUERY);
			if (adv6)  vld_s6  <= vld_s5;
			if (adv7)  vld_s7  <= vld_s6;
			if (adv8)  vld_s8  <= vld_s7;
			if (adv9)  vld_s9  <= vld_s8;
			if (adv10) vld_s10 <= vld_s9;
		end
	end

endmodule
